// ----- src/icymd_pkg.sv -----
// ----------------------------------------------------------------------------
// icymd_pkg: shared types and constants for the icy metadata demux
// Byte kinds, matcher codes, phase encoding and the stream title marker.
// ----------------------------------------------------------------------------
`default_nettype none

package icymd_pkg;

    // widths fixed by the stream format
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int INTERVAL_W = 20;
    localparam int LEN_W      = 12;   // length byte times 16
    localparam int MATCH_W    = 4;
    localparam int USER_W     = 5;

    // largest metadata block in bytes
    localparam int MAX_META_BYTES = 4080;

    // audio interval after reset
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 20'd8192;

    // byte classification
    typedef enum logic [KIND_W-1:0] {
        KIND_AUDIO = 2'd0,
        KIND_LEN   = 2'd1,
        KIND_META  = 2'd2
    } byte_kind_t;

    // tuser bit positions
    localparam int USER_KIND_LSB     = 0;
    localparam int USER_TITLE_CHAR   = 2;
    localparam int USER_TITLE_FIRST  = 3;
    localparam int USER_TITLE_MISS   = 4;

    // stream phase, one-hot
    typedef enum logic [2:0] {
        PH_AUDIO = 3'b001,
        PH_LEN   = 3'b010,
        PH_META  = 3'b100
    } phase_t;

    // matcher codes: 0..12 marker characters matched, then title states
    localparam logic [MATCH_W-1:0] M_IDLE  = 4'd0;
    localparam logic [MATCH_W-1:0] M_ONE   = 4'd1;
    localparam logic [MATCH_W-1:0] M_MARK  = 4'd13;   // marker length
    localparam logic [MATCH_W-1:0] M_FIRST = 4'd13;
    localparam logic [MATCH_W-1:0] M_IN    = 4'd14;
    localparam logic [MATCH_W-1:0] M_DONE  = 4'd15;

    localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CHAR_S     = 8'h53;

    // characters of StreamTitle=' by position
    function automatic logic [BYTE_W-1:0] marker_char(input logic [MATCH_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        begin
            case (idx)
                4'd0:    c = 8'h53;  // S
                4'd1:    c = 8'h74;  // t
                4'd2:    c = 8'h72;  // r
                4'd3:    c = 8'h65;  // e
                4'd4:    c = 8'h61;  // a
                4'd5:    c = 8'h6D;  // m
                4'd6:    c = 8'h54;  // T
                4'd7:    c = 8'h69;  // i
                4'd8:    c = 8'h74;  // t
                4'd9:    c = 8'h6C;  // l
                4'd10:   c = 8'h65;  // e
                4'd11:   c = 8'h3D;  // =
                4'd12:   c = 8'h27;  // quote
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/icy_metadata_demux.sv -----
// Output: a result is registered and appears on the master side in the cycle after its request is accepted.
// Throughput: one byte per cycle while the master side takes results; the output register is refilled in the same cycle
// that its result is taken, so only back-pressure on the master side holds up the slave side.
// Reset (rst_n low, asynchronous): audio phase, counters and matcher cleared,
// output empty, audio interval back to 8192.
// ----------------------------------------------------------------------------
// icy_metadata_demux: icy stream metadata deframer
// Classifies stream body bytes as audio, length or metadata and marks the
// stream title characters inside each metadata block.
// ----------------------------------------------------------------------------
`default_nettype none

module icy_metadata_demux #(
    parameter int MAX_META_BYTES = icymd_pkg::MAX_META_BYTES
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // configuration
    input  wire                                  cfg_wr_en,
    input  wire  [icymd_pkg::INTERVAL_W-1:0]     cfg_wr_data,   // audio_interval
    // slave side
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [icymd_pkg::BYTE_W-1:0]         s_axis_tdata,  // data_byte
    // master side
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [icymd_pkg::BYTE_W-1:0]         m_axis_tdata,  // out_byte
    // byte_kind[1:0], title_char[2], title_first[3], title_missing[4]
    output logic [icymd_pkg::USER_W-1:0]         m_axis_tuser,
    output logic                                 m_axis_tlast   // block_last
);

    localparam int META_W = $clog2(MAX_META_BYTES + 1);
    localparam logic [icymd_pkg::LEN_W-1:0] MAX_LEN =
        icymd_pkg::LEN_W'(MAX_META_BYTES);

    // state
    logic [icymd_pkg::INTERVAL_W-1:0] audio_interval_reg;
    icymd_pkg::phase_t                phase_reg, phase_next;
    logic [icymd_pkg::INTERVAL_W-1:0] audio_count_reg, audio_count_next;
    logic [META_W-1:0]                meta_rem_reg, meta_rem_next;
    logic [icymd_pkg::MATCH_W-1:0]    match_reg, match_next;

    // output register
    logic                             out_valid_reg;
    logic [icymd_pkg::BYTE_W-1:0]     out_byte_reg;
    icymd_pkg::byte_kind_t            kind_reg, kind_next;
    logic                             tchar_reg, tchar_next;
    logic                             tfirst_reg, tfirst_next;
    logic                             last_reg, last_next;
    logic                             miss_reg, miss_next;

    logic                             accept;
    logic [icymd_pkg::LEN_W-1:0]      len_raw;
    logic [icymd_pkg::LEN_W-1:0]      len_clamp;
    logic [META_W-1:0]                rem_dec;
    logic [icymd_pkg::INTERVAL_W-1:0] limit;
    logic [icymd_pkg::INTERVAL_W-1:0] count_inc;

    // handshake: output register refills as it drains
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // block length from length byte, clamped
    assign len_raw   = {s_axis_tdata, 4'b0000};
    assign len_clamp = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
    assign rem_dec   = (meta_rem_reg == '0) ? '0 : meta_rem_reg - META_W'(1);

    // audio counting, zero interval acts as one
    assign limit     = (audio_interval_reg == '0) ? icymd_pkg::INTERVAL_W'(1)
                                                  : audio_interval_reg;
    assign count_inc = audio_count_reg + icymd_pkg::INTERVAL_W'(1);

    // per-byte classification and matcher
    always_comb
    begin
        phase_next       = phase_reg;
        audio_count_next = audio_count_reg;
        meta_rem_next    = meta_rem_reg;
        match_next       = match_reg;
        kind_next        = icymd_pkg::KIND_AUDIO;
        tchar_next       = 1'b0;
        tfirst_next      = 1'b0;
        last_next        = 1'b0;
        miss_next        = 1'b0;
        case (phase_reg)
            icymd_pkg::PH_LEN:
            begin
                kind_next  = icymd_pkg::KIND_LEN;
                match_next = icymd_pkg::M_IDLE;
                if (len_clamp == '0)
                begin
                    last_next  = 1'b1;
                    phase_next = icymd_pkg::PH_AUDIO;
                end
                else
                begin
                    meta_rem_next = META_W'(len_clamp);
                    phase_next    = icymd_pkg::PH_META;
                end
            end
            icymd_pkg::PH_META:
            begin
                kind_next = icymd_pkg::KIND_META;
                if (match_reg < icymd_pkg::M_MARK)
                begin
                    if (s_axis_tdata == icymd_pkg::marker_char(match_reg))
                        match_next = match_reg + icymd_pkg::MATCH_W'(1);
                    else if (s_axis_tdata == icymd_pkg::CHAR_S)
                        match_next = icymd_pkg::M_ONE;
                    else
                        match_next = icymd_pkg::M_IDLE;
                end
                else if (match_reg == icymd_pkg::M_FIRST || match_reg == icymd_pkg::M_IN)
                begin
                    if (s_axis_tdata == icymd_pkg::CHAR_QUOTE)
                        match_next = icymd_pkg::M_DONE;
                    else
                    begin
                        tchar_next  = 1'b1;
                        tfirst_next = (match_reg == icymd_pkg::M_FIRST);
                        match_next  = icymd_pkg::M_IN;
                    end
                end
                meta_rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    last_next  = 1'b1;
                    miss_next  = (match_next < icymd_pkg::M_MARK);
                    match_next = icymd_pkg::M_IDLE;
                    phase_next = icymd_pkg::PH_AUDIO;
                end
            end
            default:
            begin
                phase_next       = icymd_pkg::PH_AUDIO;
                audio_count_next = count_inc;
                if (count_inc >= limit)
                begin
                    audio_count_next = '0;
                    phase_next       = icymd_pkg::PH_LEN;
                end
            end
        endcase
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            audio_interval_reg <= icymd_pkg::INTERVAL_RESET;
        else if (cfg_wr_en)
            audio_interval_reg <= cfg_wr_data;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= icymd_pkg::PH_AUDIO;
            audio_count_reg <= '0;
            meta_rem_reg    <= '0;
            match_reg       <= icymd_pkg::M_IDLE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                audio_count_reg <= audio_count_next;
                meta_rem_reg    <= meta_rem_next;
                match_reg       <= match_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg <= s_axis_tdata;
            kind_reg     <= kind_next;
            tchar_reg    <= tchar_next;
            tfirst_reg   <= tfirst_next;
            last_reg     <= last_next;
            miss_reg     <= miss_next;
        end
    end

    // master side outputs
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {miss_reg, tfirst_reg, tchar_reg, kind_reg};
    assign m_axis_tlast  = last_reg;

endmodule

`default_nettype wire

// ----- src/icymd_checker.sv -----
// ----------------------------------------------------------------------------
// icymd_checker: port-level checks for the icy metadata demux
// Watches the master side and checks flag consistency of results.
// ----------------------------------------------------------------------------
`default_nettype none

module icymd_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [icymd_pkg::BYTE_W-1:0]      m_axis_tdata,
    input wire [icymd_pkg::USER_W-1:0]      m_axis_tuser,
    input wire                              m_axis_tlast
);

    logic [icymd_pkg::KIND_W-1:0] kind;
    assign kind = m_axis_tuser[icymd_pkg::USER_KIND_LSB +: icymd_pkg::KIND_W];

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // missing marker only reported at block end on content bytes
    a_missing_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[icymd_pkg::USER_TITLE_MISS] |->
            m_axis_tlast && kind == icymd_pkg::KIND_META)
        else $error("title_missing without block end");

    // title characters only inside metadata
    a_title_meta: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[icymd_pkg::USER_TITLE_CHAR] |->
            kind == icymd_pkg::KIND_META && !m_axis_tuser[icymd_pkg::USER_TITLE_MISS])
        else $error("title character outside metadata");

    // first title character is a title character
    a_first_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[icymd_pkg::USER_TITLE_FIRST] |->
            m_axis_tuser[icymd_pkg::USER_TITLE_CHAR])
        else $error("title_first without title_char");

    // block end never on audio
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            kind == icymd_pkg::KIND_LEN || kind == icymd_pkg::KIND_META)
        else $error("block end on audio byte");

endmodule

bind icy_metadata_demux icymd_checker u_icymd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
